[design/rxpa_pkg.sv]
// ----------------------------------------------------------------------------
// Receive packet assembler package
// Shared payload types, command codes and constants of the packet assembler.
// ----------------------------------------------------------------------------
package rxpa_pkg;

  localparam int BUF_DEPTH      = 256;
  localparam int BUF_ADDR_W     = 8;
  localparam int DEFAULT_MAX_LEN = 255;
  localparam logic [5:0] CHUNK_RESET = 6'd50;
  localparam logic [7:0] ERR_MAX     = 8'hFF;

  localparam logic [1:0] OP_EVENT   = 2'd0;
  localparam logic [1:0] OP_FETCH   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic        fifo_almost_full;
    logic        preamble_valid;
    logic        crc_error;
    logic        packet_valid;
    logic [7:0]  reported_length;
    logic [15:0] tick;
    logic [7:0]  fifo_byte;
    logic [7:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [7:0]  fetch_count;
    logic        restart_receiver;
    logic        stop_receiver;
    logic        packet_ready;
    logic        preamble_seen;
    logic [7:0]  packet_length;
    logic [7:0]  error_count;
    logic [7:0]  data_byte;
    logic [15:0] arrival_tick;
  } out_t;

  // Classified command: the byte field carries the length, the FIFO byte or
  // the read index, depending on the kind.
  typedef struct packed {
    logic [1:0]  kind;
    logic        almost_full;
    logic        preamble;
    logic        crc_bad;
    logic        pkt_valid;
    logic [7:0]  value;
    logic [15:0] tick;
  } cmd_t;

endpackage

[design/radio_rx_packet_assembler_core.sv]
// ----------------------------------------------------------------------------
// Radio receive packet assembler
// Receive controller that requests FIFO chunks, stores packet bytes, holds a
// finished packet for the host and counts receive errors.
// ----------------------------------------------------------------------------
// The block takes one input transaction per clock cycle while in_ready is high
// and returns one result transaction for each, in order. The command is
// registered in the two-entry command queue at the accepting edge, and the back
// end's state update and registered packet buffer read then place the result in
// its output register when the back end advances.
// When the output is stalled the back end holds its result and the queue
// absorbs up to two further transactions before input ready drops.
// The packet buffer has no reset; a host read within the held packet returns
// whatever the addressed entry last held, and any other read returns zero.
module radio_rx_packet_assembler_core #(
  parameter int MAX_PACKET_LEN = rxpa_pkg::DEFAULT_MAX_LEN
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write_en,
  input  logic [5:0]     cfg_write_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  rxpa_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rxpa_pkg::out_t out_data
);
  import rxpa_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic queue_full;
  logic head_valid;

  rxpa_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (front_cmd)
  );

  rxpa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (front_cmd),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  rxpa_back #(
    .MAX_PACKET_LEN (MAX_PACKET_LEN)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .cmd_valid      (head_valid),
    .cmd            (head_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

[design/rxpa_front.sv]
// ----------------------------------------------------------------------------
// Receive packet assembler front end
// Accepts input transactions and packs them into compact commands.
// ----------------------------------------------------------------------------
module rxpa_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  rxpa_pkg::in_t  in_data,
  input  logic           queue_full,
  output logic           push,
  output rxpa_pkg::cmd_t cmd
);
  import rxpa_pkg::*;

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    cmd = '0;
    cmd.kind = in_data.operation;
    unique case (in_data.operation)
      OP_EVENT: begin
        cmd.almost_full = in_data.fifo_almost_full;
        cmd.preamble    = in_data.preamble_valid;
        cmd.crc_bad     = in_data.crc_error;
        cmd.pkt_valid   = in_data.packet_valid;
        cmd.value       = in_data.reported_length;
        cmd.tick        = in_data.tick;
      end
      OP_FETCH: begin
        cmd.value = in_data.fifo_byte;
      end
      OP_READ: begin
        cmd.value = in_data.read_index;
      end
      default: begin
        cmd.value = '0;
      end
    endcase
  end

endmodule

[design/rxpa_queue.sv]
// ----------------------------------------------------------------------------
// Receive packet assembler command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rxpa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rxpa_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           head_valid,
  output rxpa_pkg::cmd_t head_cmd,
  input  logic           pop
);
  import rxpa_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/rxpa_back.sv]
// ----------------------------------------------------------------------------
// Receive packet assembler back end
// Executes commands on the receive state and the packet buffer, and holds the
// result transaction until it is taken.
// ----------------------------------------------------------------------------
module rxpa_back #(
  parameter int MAX_PACKET_LEN = rxpa_pkg::DEFAULT_MAX_LEN
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write_en,
  input  logic [5:0]     cfg_write_data,
  input  logic           cmd_valid,
  input  rxpa_pkg::cmd_t cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output rxpa_pkg::out_t out_data
);
  import rxpa_pkg::*;

  localparam logic [8:0] MaxLen = 9'(MAX_PACKET_LEN);

  logic [7:0]  buffer [BUF_DEPTH];
  logic [7:0]  buf_q;

  logic [5:0]  chunk_size;
  logic [7:0]  requested_length, requested_length_next;
  logic [7:0]  write_pointer, write_pointer_next;
  logic [7:0]  held_length, held_length_next;
  logic        ready_flag, ready_flag_next;
  logic        preamble_flag, preamble_flag_next;
  logic [7:0]  error_counter, error_counter_next;
  logic [15:0] arrival_time, arrival_time_next;

  logic        res_valid;
  out_t        res;
  out_t        res_next;
  logic        rd_hit, rd_hit_q;
  logic        wr_hit;
  logic        advance;
  logic        done;
  logic        err_hit;
  logic        rearm;
  logic [8:0]  chunk_sum;
  logic [7:0]  fetch;

  assign advance = cmd_valid && (!res_valid || out_ready);
  assign pop     = advance;

  always_comb begin
    requested_length_next = requested_length;
    write_pointer_next    = write_pointer;
    held_length_next      = held_length;
    ready_flag_next       = ready_flag;
    preamble_flag_next    = preamble_flag;
    arrival_time_next     = arrival_time;
    error_counter_next    = error_counter;
    res_next              = '0;
    done                  = 1'b0;
    err_hit               = 1'b0;
    rearm                 = 1'b0;
    rd_hit                = 1'b0;
    wr_hit                = 1'b0;
    fetch                 = '0;
    chunk_sum             = {1'b0, requested_length} + {3'b000, chunk_size};

    unique case (cmd.kind)
      OP_EVENT: begin
        if (!ready_flag) begin
          if (cmd.almost_full) begin
            if (chunk_sum > MaxLen) begin
              err_hit = 1'b1;
              rearm   = 1'b1;
              done    = 1'b1;
            end else begin
              fetch                 = {2'b00, chunk_size};
              requested_length_next = chunk_sum[7:0];
            end
          end
          if (!done && cmd.preamble) begin
            preamble_flag_next = 1'b1;
          end
          if (!done && cmd.crc_bad) begin
            err_hit = 1'b1;
            rearm   = 1'b1;
            done    = 1'b1;
          end
          if (!done && cmd.pkt_valid) begin
            arrival_time_next = cmd.tick;
            if (({1'b0, cmd.value} > MaxLen) || (requested_length_next > cmd.value)) begin
              err_hit = 1'b1;
              rearm   = 1'b1;
            end else begin
              fetch                  = fetch + (cmd.value - requested_length_next);
              requested_length_next  = cmd.value;
              held_length_next       = cmd.value;
              ready_flag_next        = 1'b1;
              res_next.stop_receiver = 1'b1;
            end
          end
        end
      end
      OP_FETCH: begin
        if (write_pointer < requested_length) begin
          wr_hit             = 1'b1;
          write_pointer_next = write_pointer + 8'd1;
        end
      end
      OP_READ: begin
        rd_hit = ready_flag && (cmd.value < held_length);
      end
      default: begin
        rearm = ready_flag;
      end
    endcase

    if (err_hit && (error_counter != ERR_MAX)) begin
      error_counter_next = error_counter + 8'd1;
    end
    if (rearm) begin
      requested_length_next = '0;
      write_pointer_next    = '0;
      held_length_next      = '0;
      ready_flag_next       = 1'b0;
      preamble_flag_next    = 1'b0;
    end

    res_next.fetch_count      = fetch;
    res_next.restart_receiver = rearm;
    res_next.packet_ready     = ready_flag_next;
    res_next.preamble_seen    = preamble_flag_next;
    res_next.packet_length    = held_length_next;
    res_next.error_count      = error_counter_next;
    res_next.arrival_tick     = arrival_time_next;
  end

  always_ff @(posedge clk) begin
    if (advance && wr_hit) begin
      buffer[write_pointer] <= cmd.value;
    end
    if (advance) begin
      buf_q <= buffer[cmd.value];
      res   <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size       <= CHUNK_RESET;
      requested_length <= '0;
      write_pointer    <= '0;
      held_length      <= '0;
      ready_flag       <= 1'b0;
      preamble_flag    <= 1'b0;
      error_counter    <= '0;
      arrival_time     <= '0;
      res_valid        <= 1'b0;
      rd_hit_q         <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        chunk_size <= cfg_write_data;
      end
      if (advance) begin
        requested_length <= requested_length_next;
        write_pointer    <= write_pointer_next;
        held_length      <= held_length_next;
        ready_flag       <= ready_flag_next;
        preamble_flag    <= preamble_flag_next;
        error_counter    <= error_counter_next;
        arrival_time     <= arrival_time_next;
        rd_hit_q         <= rd_hit;
        res_valid        <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign out_valid = res_valid;

  always_comb begin
    out_data           = res;
    out_data.data_byte = rd_hit_q ? buf_q : 8'd0;
  end

endmodule
